// ===== rtl/polygon_point_inside_test_assert.svh =====
// Assertion macros for the polygon point-inside test block.
// Used by files that include this header. It assumes the including module has i_clk and i_rst_n.
`ifndef POLYGON_POINT_INSIDE_TEST_ASSERT_SVH
`define POLYGON_POINT_INSIDE_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// Item types, command codes and status codes for the polygon point-inside test.
// It has no dependencies. The cell and the top level import it.
package pip_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic       inside_res;
        logic [1:0] status;
    } t_out_item;

    // These are the control signals for one vertex cell.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

endpackage

// ===== rtl/pip_cell.sv =====
// This file holds one vertex cell of the rotating vertex ring.
// It depends on pip_pkg for the cell control struct.
module pip_cell #(
    parameter int CW = 16
) (
    input  logic                i_clk,
    input  pip_pkg::t_cell_ctl  i_ctl,
    input  logic [CW-1:0]       i_load_x,
    input  logic [CW-1:0]       i_load_y,
    input  logic [CW-1:0]       i_nb_x,
    input  logic [CW-1:0]       i_nb_y,
    output logic [CW-1:0]       o_x,
    output logic [CW-1:0]       o_y
);
    import pip_pkg::*;

    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;

    // A shift takes the neighbor's vertex, and a load takes a new vertex from the append.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x <= i_nb_x;
            r_y <= i_nb_y;
        end else if (i_ctl.load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ===== rtl/polygon_point_inside_test.sv =====
// This is the top level of the point-in-polygon crossing-number test: a ring of vertex cells,
// a two-stage edge evaluator and the control. It depends on pip_pkg, pip_cell and the assert header.
//
//  channel | valid       | stall        | payload
//  input   | i_in_valid  | o_in_stall   | i_in_item  (command, x_coord, y_coord)
//  output  | o_out_valid | i_out_stall  | o_out_item (inside_res, status)
//
// A query that is rejected early goes straight to the result state. A full query runs while
// the vertex ring rotates once through all of its cells, and then one evaluator stage
// drains.
// The synchronous active-low reset empties the polygon and the output register.
// The block takes no new item while a query is in progress or while its result has not
// been placed in the output register.

`include "polygon_point_inside_test_assert.svh"

module polygon_point_inside_test #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pip_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output pip_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import pip_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int PW = 2 * CW + 4;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    r_state;
    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic          r_ovf;
    logic          r_par, r_hit;
    logic [CW-1:0] r_yp, r_last_y;
    logic [CW-1:0] r_qx, r_qy, r_v0x, r_v0y;
    logic [IW-1:0] r_step;
    logic          r_res_in;
    logic [1:0]    r_res_st;
    logic          r_ov;
    t_out_item     r_out;
    logic          r_a_on, r_a_tog, r_a_slp;
    logic signed [PW-1:0] r_n, r_lo, r_d;

    logic [31:0]   w_xw, w_yw;
    logic [CW-1:0] w_px, w_py;
    logic          w_acc, w_app, w_inbox, w_ev, w_last;
    logic [CW-1:0] w_cx [MAX_VERTICES];
    logic [CW-1:0] w_cy [MAX_VERTICES];
    logic [CW-1:0] w_x0, w_y0, w_x1, w_y1;

    assign w_xw  = 32'(i_in_item.x_coord);
    assign w_yw  = 32'(i_in_item.y_coord);
    assign w_px  = w_xw[CW-1:0];
    assign w_py  = w_yw[CW-1:0];
    assign w_acc = i_in_valid && !o_in_stall;
    assign w_app = w_acc && i_in_item.command == CMD_APPEND && r_cnt < NW'(MAX_VERTICES);
    assign w_inbox = w_px >= r_min_x && w_px <= r_max_x && w_py >= r_min_y && w_py <= r_max_y;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // During a query the ring shifts toward cell 0 on every cycle, so cell 0 and cell 1 hold
    // the current edge. After one full rotation the ring is back in its original order.
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.shift = r_state == S_RUN;
        assign w_ctl.load  = w_app && r_cnt[IW-1:0] == IW'(g);
        pip_cell #(.CW(CW)) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_load_x (w_px),
            .i_load_y (w_py),
            .i_nb_x   (w_cx[(g + 1) % MAX_VERTICES]),
            .i_nb_y   (w_cy[(g + 1) % MAX_VERTICES]),
            .o_x      (w_cx[g]),
            .o_y      (w_cy[g])
        );
    end

    assign w_ev   = r_state == S_RUN && NW'(r_step) < r_cnt;
    assign w_last = NW'(r_step) == r_cnt - NW'(1);
    assign w_x0   = w_cx[0];
    assign w_y0   = w_cy[0];
    assign w_x1   = w_last ? r_v0x : w_cx[1];
    assign w_y1   = w_last ? r_v0y : w_cy[1];

    // This is evaluator stage A: the edge case checks and the two cross products.
    logic signed [CW+1:0] s_x, s_y, s_x0, s_y0, s_x1, s_y1, s_yp;
    logic signed [CW+1:0] s_a, s_b, s_num, s_den;
    logic                 a_on, a_tog, a_slp, a_le0, a_neg;
    logic signed [PW-1:0] a_n, a_lo;

    always_comb begin
        s_x   = $signed({2'b00, r_qx});
        s_y   = $signed({2'b00, r_qy});
        s_x0  = $signed({2'b00, w_x0});
        s_y0  = $signed({2'b00, w_y0});
        s_x1  = $signed({2'b00, w_x1});
        s_y1  = $signed({2'b00, w_y1});
        s_yp  = $signed({2'b00, r_yp});
        s_a   = s_y - s_yp;
        s_b   = s_y - s_y1;
        a_le0 = s_a == 0 || s_b == 0 || s_a[CW+1] != s_b[CW+1];
        a_neg = s_y1 < s_y0;
        s_num = a_neg ? s_y0 - s_y : s_y - s_y0;
        s_den = a_neg ? s_y0 - s_y1 : s_y1 - s_y0;
        a_n   = PW'(s_num) * PW'(s_x1 - s_x0);
        a_lo  = PW'(s_x - s_x0) * PW'(s_den);
        a_on  = 1'b0;
        a_tog = 1'b0;
        a_slp = 1'b0;
        priority if ((s_x0 < s_x && s_x1 < s_x) ||
                     (s_y0 < s_y && s_y1 < s_y) || (s_y0 > s_y && s_y1 > s_y)) begin
            a_on = 1'b0;
        end else if ((s_x0 == s_x && s_y0 == s_y) || (s_x1 == s_x && s_y1 == s_y)) begin
            a_on = 1'b1;
        end else if (s_y0 == s_y1) begin
            a_on = !(s_x0 > s_x && s_x1 > s_x);
        end else if (s_x0 == s_x1) begin
            a_tog = s_y != s_y0 && s_y != s_y1;
        end else if (s_y == s_y0) begin
            a_tog = s_x < s_x0 && a_le0;
        end else if (s_y == s_y1) begin
            a_tog = 1'b0;
        end else begin
            a_slp = 1'b1;
        end
    end

    // This is evaluator stage B: the truncated crossing abscissa is compared with x.
    logic b_tog, b_on;
    always_comb begin
        b_tog = r_a_tog || (r_a_slp && r_n >= r_lo + r_d);
        b_on  = r_a_on || (r_a_slp && r_n < r_lo + r_d && r_n >= r_lo);
    end

    always_ff @(posedge i_clk) begin
        r_a_on  <= w_ev && a_on;
        r_a_tog <= w_ev && a_tog;
        r_a_slp <= w_ev && a_slp;
        r_n     <= a_n;
        r_lo    <= a_lo;
        r_d     <= PW'(s_den);
        if (r_state == S_RUN && r_step == '0) begin
            r_v0x <= w_x0;
            r_v0y <= w_y0;
        end
        if (w_acc) begin
            r_qx <= w_px;
            r_qy <= w_py;
        end
        if (r_state == S_DONE && (!r_ov || !i_out_stall)) begin
            r_out.inside_res <= r_res_in;
            r_out.status     <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_min_x  <= '1;
            r_min_y  <= '1;
            r_max_x  <= '0;
            r_max_y  <= '0;
            r_ovf    <= 1'b0;
            r_par    <= 1'b0;
            r_hit    <= 1'b0;
            r_yp     <= '0;
            r_last_y <= '0;
            r_step   <= '0;
            r_res_in <= 1'b0;
            r_res_st <= ST_OK;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_in_item.command)
                            CMD_CLEAR: begin
                                r_cnt   <= '0;
                                r_min_x <= '1;
                                r_min_y <= '1;
                                r_max_x <= '0;
                                r_max_y <= '0;
                                r_ovf   <= 1'b0;
                            end
                            CMD_APPEND: begin
                                if (!w_app) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_cnt    <= r_cnt + NW'(1);
                                    r_last_y <= w_py;
                                    if (w_px < r_min_x) r_min_x <= w_px;
                                    if (w_px > r_max_x) r_max_x <= w_px;
                                    if (w_py < r_min_y) r_min_y <= w_py;
                                    if (w_py > r_max_y) r_max_y <= w_py;
                                end
                            end
                            CMD_QUERY: begin
                                r_res_st <= (r_cnt < NW'(2)) ? ST_FEW : (r_ovf ? ST_DROP : ST_OK);
                                r_res_in <= 1'b0;
                                r_par    <= 1'b0;
                                r_hit    <= 1'b0;
                                r_step   <= '0;
                                r_yp     <= r_last_y;
                                if (r_cnt < NW'(2) || !w_inbox) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RUN;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_par  <= r_par ^ b_tog;
                    r_hit  <= r_hit | b_on;
                    r_yp   <= w_y0;
                    r_step <= r_step + IW'(1);
                    if (r_step == IW'(MAX_VERTICES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_res_in <= r_hit | b_on | (r_par ^ b_tog);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PIP_ASSERT_SAME(a_cnt_max, 1'b1, r_cnt <= NW'(MAX_VERTICES), "vertex count beyond store")
    `PIP_ASSERT_NEXT(a_few_done, w_acc && i_in_item.command == CMD_QUERY && r_cnt < NW'(2), r_state == S_DONE && r_res_st == ST_FEW, "short polygon query not answered at once")
    `PIP_ASSERT_SAME(a_drain_after_run, r_state == S_DRAIN, $past(r_state) == S_RUN, "drain entered without a ring pass")

endmodule

// ===== dv/pip_checker.sv =====
// Checker for the polygon point-inside test: watches both channels, keeps its own
// polygon state, predicts each query answer and compares. Depends on pip_pkg.
`timescale 1ns / 100ps

module pip_checker
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_item i_out_item,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_pending
);

    logic [15:0] poly_x [MAX_VERTICES];
    logic [15:0] poly_y [MAX_VERTICES];
    int unsigned poly_len;
    logic [15:0] min_x, max_x, min_y, max_y;
    logic        dropped;
    t_out_item   answers_due [$];

    // Result of one edge visit: on the boundary, or a crossing toggle.
    function automatic logic edge_on(input longint x, input longint y, input longint x0,
                                     input longint y0, input longint x1, input longint y1,
                                     input longint yp, inout logic parity);
        longint num, den, lo;
        if (x0 < x && x1 < x) return 1'b0;
        if ((y0 < y && y1 < y) || (y0 > y && y1 > y)) return 1'b0;
        if ((x0 == x && y0 == y) || (x1 == x && y1 == y)) return 1'b1;
        if (y0 == y1) return !(x0 > x && x1 > x);
        if (x0 == x1) begin
            if (y != y0 && y != y1) parity = ~parity;
            return 1'b0;
        end
        if (y == y0) begin
            if (x < x0 && (y - yp) * (y - y1) <= 0) parity = ~parity;
            return 1'b0;
        end
        if (y == y1) return 1'b0;
        num = (y - y0) * (x1 - x0);
        den = y1 - y0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        lo = (x - x0) * den;
        if (num >= lo + den) begin
            parity = ~parity;
            return 1'b0;
        end
        return num >= lo;
    endfunction

    function automatic t_out_item query_answer(input logic [15:0] px, input logic [15:0] py);
        t_out_item   ans;
        logic        parity;
        longint      yp;
        int unsigned nxt;
        ans = '0;
        parity = 1'b0;
        if (poly_len < 2) begin
            ans.status = ST_FEW;
            return ans;
        end
        ans.status = dropped ? ST_DROP : ST_OK;
        if (px < min_x || px > max_x || py < min_y || py > max_y) return ans;
        yp = poly_y[poly_len - 1];
        for (int unsigned k = 0; k < poly_len; k++) begin
            nxt = (k + 1 < poly_len) ? k + 1 : 0;
            if (edge_on(px, py, poly_x[k], poly_y[k], poly_x[nxt], poly_y[nxt], yp, parity)) begin
                ans.inside_res = 1'b1;
                return ans;
            end
            yp = poly_y[k];
        end
        ans.inside_res = parity;
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            poly_len <= 0;
            min_x <= '1;
            min_y <= '1;
            max_x <= '0;
            max_y <= '0;
            dropped <= 1'b0;
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                case (i_in_item.command)
                    CMD_CLEAR: begin
                        poly_len <= 0;
                        min_x <= '1;
                        min_y <= '1;
                        max_x <= '0;
                        max_y <= '0;
                        dropped <= 1'b0;
                    end
                    CMD_APPEND: begin
                        if (poly_len >= MAX_VERTICES) begin
                            dropped <= 1'b1;
                        end else begin
                            poly_x[poly_len] <= i_in_item.x_coord;
                            poly_y[poly_len] <= i_in_item.y_coord;
                            poly_len <= poly_len + 1;
                            if (i_in_item.x_coord < min_x) min_x <= i_in_item.x_coord;
                            if (i_in_item.x_coord > max_x) max_x <= i_in_item.x_coord;
                            if (i_in_item.y_coord < min_y) min_y <= i_in_item.y_coord;
                            if (i_in_item.y_coord > max_y) max_y <= i_in_item.y_coord;
                        end
                    end
                    CMD_QUERY: begin
                        answers_due.push_back(query_answer(i_in_item.x_coord,
                                                           i_in_item.y_coord));
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result item %p", i_out_item);
                    errs++;
                end else begin
                    due = answers_due.pop_front();
                    if (due.inside_res !== i_out_item.inside_res) begin
                        $error("inside_res: expected %0d, got %0d", due.inside_res,
                               i_out_item.inside_res);
                        errs++;
                    end
                    if (due.status !== i_out_item.status) begin
                        $error("status: expected %0d, got %0d", due.status,
                               i_out_item.status);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
    end

    assign o_pending = answers_due.size();

endmodule

// ===== dv/tb_polygon_point_inside_test.sv =====
// Testbench top for the polygon point-inside test: drives polygon loads and queries
// with random gaps and output stalls. Depends on pip_pkg, pip_checker and the block.
`timescale 1ns / 100ps

module tb_polygon_point_inside_test;
    import pip_pkg::*;

    localparam int MAX_VERTICES = 256;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;
    int        fail_count;
    int        pending;
    int        stall_mode = 0;

    polygon_point_inside_test #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(16)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_item(in_item), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_item(out_item), .i_out_stall(out_stall)
    );

    pip_checker #(.MAX_VERTICES(MAX_VERTICES)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_item(in_item), .i_in_stall(in_stall),
        .i_out_valid(out_valid), .i_out_item(out_item), .i_out_stall(out_stall),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Receiver stalls: the mode changes now and then, including long runs without stall.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    int gap_left;
    int burst_left;

    // Offers one item and holds it until accepted; gaps fall between bursts.
    // Valid stays high after acceptance until the next call replaces the item or starts a gap.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] x, input logic [15:0] y);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                repeat (gap_left) @(negedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= '{command: cmd, x_coord: x, y_coord: y};
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord(input int span);
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(32768 + $urandom_range(0, span));
            default: return 16'(30000 + $urandom_range(0, span));
        endcase
    endfunction

    // Builds a random polygon of a mostly small vertex count, then queries it.
    task automatic random_polygon();
        int nv;
        int span;
        span = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(2, 60);
        case ($urandom_range(0, 9))
            0: nv = $urandom_range(0, 1);
            1: nv = $urandom_range(MAX_VERTICES - 2, MAX_VERTICES + 3);
            default: nv = $urandom_range(2, 12);
        endcase
        send_item(CMD_CLEAR, 16'($urandom), 16'($urandom));
        for (int k = 0; k < nv; k++) begin
            if (span == 65535) send_item(CMD_APPEND, 16'($urandom), 16'($urandom));
            else send_item(CMD_APPEND, 16'(30000 + $urandom_range(0, span)),
                           16'(30000 + $urandom_range(0, span)));
        end
        repeat ($urandom_range(2, 10)) begin
            case ($urandom_range(0, 19))
                0: send_item(2'd3, 16'($urandom), 16'($urandom));
                1: send_item(CMD_QUERY, rand_coord(65535), rand_coord(65535));
                2: send_item(CMD_QUERY, 16'($urandom), 16'($urandom));
                default: send_item(CMD_QUERY,
                                   16'(30000 + $urandom_range(0, span > 60 ? 65535 - 30000 : span)),
                                   16'(30000 + $urandom_range(0, span > 60 ? 65535 - 30000 : span)));
            endcase
        end
    endtask

    initial begin
        int sent;
        int settle;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        burst_left = 0;
        gap_left = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty and single-vertex polygons, a square with its
        // inside, vertex, edge and outside points, a diamond with vertices at
        // ray level, a full-range triangle and the unused command.
        send_item(CMD_QUERY, 16'd5, 16'd5);
        send_item(CMD_APPEND, 16'd10, 16'd10);
        send_item(CMD_QUERY, 16'd10, 16'd10);
        send_item(CMD_CLEAR, 16'd0, 16'd0);
        send_item(CMD_APPEND, 16'd10, 16'd10);
        send_item(CMD_APPEND, 16'd20, 16'd10);
        send_item(CMD_APPEND, 16'd20, 16'd20);
        send_item(CMD_APPEND, 16'd10, 16'd20);
        send_item(CMD_QUERY, 16'd15, 16'd15);
        send_item(CMD_QUERY, 16'd10, 16'd10);
        send_item(CMD_QUERY, 16'd15, 16'd10);
        send_item(CMD_QUERY, 16'd20, 16'd15);
        send_item(CMD_QUERY, 16'd25, 16'd15);
        send_item(2'd3, 16'hFFFF, 16'hFFFF);
        send_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send_item(CMD_APPEND, 16'd50, 16'd0);
        send_item(CMD_APPEND, 16'd100, 16'd50);
        send_item(CMD_APPEND, 16'd50, 16'd100);
        send_item(CMD_APPEND, 16'd0, 16'd50);
        send_item(CMD_QUERY, 16'd10, 16'd50);
        send_item(CMD_QUERY, 16'd74, 16'd25);
        send_item(CMD_QUERY, 16'd75, 16'd25);
        send_item(CMD_CLEAR, 16'd0, 16'd0);
        send_item(CMD_APPEND, 16'h0000, 16'h0000);
        send_item(CMD_APPEND, 16'hFFFF, 16'h0000);
        send_item(CMD_APPEND, 16'hFFFF, 16'hFFFF);
        send_item(CMD_QUERY, 16'hFFFE, 16'h0001);

        sent = 0;
        while (sent < 26) begin
            random_polygon();
            sent++;
        end
        in_valid <= 1'b0;

        settle = 0;
        while (pending != 0 && settle < 100000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (MAX_VERTICES + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
